### rtl/core/tcs_pkg.sv
package tcs_pkg;

  localparam int SCREEN_ROWS = 10;
  localparam int SCREEN_COLS = 10;

  localparam int POS_W  = 4;
  localparam int CHAR_W = 8;

  localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_B     = 8'h62;
  localparam logic [CHAR_W-1:0] CH_C     = 8'h63;
  localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
  localparam logic [CHAR_W-1:0] CH_E     = 8'h65;
  localparam logic [CHAR_W-1:0] CH_H     = 8'h68;
  localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
  localparam logic [CHAR_W-1:0] CH_L     = 8'h6C;
  localparam logic [CHAR_W-1:0] CH_O     = 8'h6F;
  localparam logic [CHAR_W-1:0] CH_R     = 8'h72;
  localparam logic [CHAR_W-1:0] CH_U     = 8'h75;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_TEXT,
    PH_CARET,
    PH_ROW
  } phase_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUT,
    OP_ERASE,
    OP_CLEAR,
    OP_READ,
    OP_READ_OOR
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [CHAR_W-1:0] ch;
    logic              ins;
  } row_op_t;

endpackage

### rtl/core/terminal_control_sequence_screen.sv
// Character-cell text screen fed by a byte stream.
// Input channel (in_valid/in_stall): req_type 0 feeds byte_in to the stream
// parser, req_type 1 reads the cell at read_row/read_col.
// Output channel (out_valid/out_stall): one transfer per input transfer, in
// order, carrying cell_char (0 for feeds), the cursor after the item and the
// insert mode.
// Throughput is one item per cycle while the output is not stalled. The row
// memory read is registered at the input transfer, and the row edit is then
// registered into the output register, which raises out_valid.
// The row memory holds one screen row per entry; a write followed at once by
// a read of the same row is forwarded from a bypass register.
// Reset (rst, synchronous) homes the cursor, selects overwrite mode and
// marks every row blank through per-row valid flags, so no clearing sweep is
// needed; ^c clears all the same flags together.
// When the receiver stalls the output register holds; the edit stage and then
// the input stall in turn, and nothing is lost.
module terminal_control_sequence_screen #(
  parameter int SCREEN_ROWS = tcs_pkg::SCREEN_ROWS,
  parameter int SCREEN_COLS = tcs_pkg::SCREEN_COLS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        req_type,
  input  logic [tcs_pkg::CHAR_W-1:0]  byte_in,
  input  logic [tcs_pkg::POS_W-1:0]   read_row,
  input  logic [tcs_pkg::POS_W-1:0]   read_col,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tcs_pkg::CHAR_W-1:0]  cell_char,
  output logic [tcs_pkg::POS_W-1:0]   cur_row,
  output logic [tcs_pkg::POS_W-1:0]   cur_col,
  output logic                        insert_on
);

  localparam int AW    = $clog2(SCREEN_ROWS);
  localparam int ROW_W = SCREEN_COLS * tcs_pkg::CHAR_W;
  localparam logic [tcs_pkg::POS_W-1:0] NUM_ROWS = tcs_pkg::POS_W'(SCREEN_ROWS);
  localparam logic [tcs_pkg::POS_W-1:0] NUM_COLS = tcs_pkg::POS_W'(SCREEN_COLS);

  logic                        in_fire;
  tcs_pkg::row_op_t            op;
  logic [tcs_pkg::POS_W-1:0]   cursor_row_next, cursor_col_next;
  logic                        insert_flag_next;

  logic                        s1_valid;
  tcs_pkg::row_op_t            s1_op;
  logic [tcs_pkg::POS_W-1:0]   s1_row, s1_col;
  logic                        s1_ins;
  logic                        s1_fwd;
  logic                        s1_go;
  logic [AW-1:0]               s1_addr;
  logic                        s1_row_ok;

  logic [SCREEN_ROWS-1:0]      row_valid;
  logic [ROW_W-1:0]            ram_q;
  logic [ROW_W-1:0]            fwd_data;
  logic [SCREEN_COLS-1:0][tcs_pkg::CHAR_W-1:0] old_row, new_row;
  logic                        edit_we;
  logic                        wr_en;
  logic [tcs_pkg::CHAR_W-1:0]  edit_cell;

  assign s1_go    = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;
  assign in_fire  = in_valid && !in_stall;
  assign wr_en    = s1_go && edit_we;
  assign s1_addr  = s1_op.row[AW-1:0];
  assign s1_row_ok = s1_op.row < NUM_ROWS;

  tcs_parser #(
    .SCREEN_ROWS(SCREEN_ROWS),
    .SCREEN_COLS(SCREEN_COLS)
  ) u_parser (
    .clk             (clk),
    .rst             (rst),
    .fire            (in_fire),
    .req_type        (req_type),
    .byte_in         (byte_in),
    .read_row        (read_row),
    .read_col        (read_col),
    .op              (op),
    .cursor_row_next (cursor_row_next),
    .cursor_col_next (cursor_col_next),
    .insert_flag_next(insert_flag_next)
  );

  tcs_ram #(
    .WIDTH(ROW_W),
    .DEPTH(SCREEN_ROWS)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(s1_addr),
    .wdata(new_row),
    .re   (in_fire),
    .raddr(op.row[AW-1:0]),
    .rdata(ram_q)
  );

  always_comb begin
    old_row = ram_q;
    if (s1_fwd) old_row = fwd_data;
    if (!s1_row_ok || !row_valid[s1_addr]) old_row = {SCREEN_COLS{tcs_pkg::CH_SPACE}};
  end

  tcs_row_edit #(
    .SCREEN_COLS(SCREEN_COLS)
  ) u_edit (
    .op       (s1_op),
    .old_row  (old_row),
    .new_row  (new_row),
    .we       (edit_we),
    .read_char(edit_cell)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      row_valid <= '0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (s1_go) begin
        if (s1_op.kind == tcs_pkg::OP_CLEAR) begin
          row_valid <= '0;
        end else if (edit_we) begin
          row_valid[s1_addr] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op  <= op;
      s1_row <= cursor_row_next;
      s1_col <= cursor_col_next;
      s1_ins <= insert_flag_next;
      s1_fwd <= wr_en && (s1_op.row == op.row);
    end
    if (wr_en) begin
      fwd_data <= new_row;
    end
    if (s1_go) begin
      cell_char <= edit_cell;
      cur_row   <= s1_row;
      cur_col   <= s1_col;
      insert_on <= s1_ins;
    end
  end

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cur_row < NUM_ROWS) && (cur_col < NUM_COLS))
    else $error("cursor outside screen");

  a_fire_fills_s1: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1_valid)
    else $error("accepted transfer lost before edit stage");

  a_clear_rows: assert property (@(posedge clk) disable iff (rst)
    (s1_go && (s1_op.kind == tcs_pkg::OP_CLEAR)) |=> (row_valid == '0))
    else $error("screen clear left a row valid");

  a_write_needs_stage: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> s1_valid && ((s1_op.kind == tcs_pkg::OP_PUT) ||
                           (s1_op.kind == tcs_pkg::OP_ERASE)))
    else $error("row write without put or erase");

endmodule

### rtl/core/tcs_ram.sv
module tcs_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/tcs_parser.sv
module tcs_parser #(
  parameter int SCREEN_ROWS = tcs_pkg::SCREEN_ROWS,
  parameter int SCREEN_COLS = tcs_pkg::SCREEN_COLS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic                         req_type,
  input  logic [tcs_pkg::CHAR_W-1:0]   byte_in,
  input  logic [tcs_pkg::POS_W-1:0]    read_row,
  input  logic [tcs_pkg::POS_W-1:0]    read_col,
  output tcs_pkg::row_op_t             op,
  output logic [tcs_pkg::POS_W-1:0]    cursor_row_next,
  output logic [tcs_pkg::POS_W-1:0]    cursor_col_next,
  output logic                         insert_flag_next
);

  localparam logic [tcs_pkg::POS_W-1:0] LAST_ROW = tcs_pkg::POS_W'(SCREEN_ROWS - 1);
  localparam logic [tcs_pkg::POS_W-1:0] LAST_COL = tcs_pkg::POS_W'(SCREEN_COLS - 1);
  localparam logic [tcs_pkg::POS_W-1:0] NUM_ROWS = tcs_pkg::POS_W'(SCREEN_ROWS);
  localparam logic [tcs_pkg::POS_W-1:0] NUM_COLS = tcs_pkg::POS_W'(SCREEN_COLS);

  tcs_pkg::phase_t             phase, phase_next;
  logic [tcs_pkg::POS_W-1:0]   pending_row, pending_row_next;
  logic [tcs_pkg::POS_W-1:0]   cursor_row, cursor_col;
  logic                        insert_flag;
  logic [tcs_pkg::CHAR_W-1:0]  digit8;
  logic [tcs_pkg::POS_W-1:0]   digit;
  logic                        is_digit;
  logic                        do_put;

  assign digit8   = byte_in - tcs_pkg::CH_ZERO;
  assign digit    = digit8[tcs_pkg::POS_W-1:0];
  assign is_digit = (byte_in >= tcs_pkg::CH_ZERO) && (byte_in <= tcs_pkg::CH_NINE);

  always_comb begin
    phase_next       = phase;
    pending_row_next = pending_row;
    cursor_row_next  = cursor_row;
    cursor_col_next  = cursor_col;
    insert_flag_next = insert_flag;
    do_put           = 1'b0;
    op.kind          = tcs_pkg::OP_NONE;
    op.row           = cursor_row;
    op.col           = cursor_col;
    op.ch            = byte_in;
    op.ins           = insert_flag;
    if (req_type) begin
      op.row = read_row;
      op.col = read_col;
      if ((read_row < NUM_ROWS) && (read_col < NUM_COLS)) begin
        op.kind = tcs_pkg::OP_READ;
      end else begin
        op.kind = tcs_pkg::OP_READ_OOR;
      end
    end else begin
      case (phase)
        tcs_pkg::PH_CARET: begin
          phase_next = tcs_pkg::PH_TEXT;
          case (byte_in)
            tcs_pkg::CH_B: cursor_col_next = '0;
            tcs_pkg::CH_C: op.kind = tcs_pkg::OP_CLEAR;
            tcs_pkg::CH_D: begin
              if (cursor_row < LAST_ROW) cursor_row_next = cursor_row + 1'b1;
            end
            tcs_pkg::CH_U: begin
              if (cursor_row != '0) cursor_row_next = cursor_row - 1'b1;
            end
            tcs_pkg::CH_L: begin
              if (cursor_col != '0) cursor_col_next = cursor_col - 1'b1;
            end
            tcs_pkg::CH_R: begin
              if (cursor_col < LAST_COL) cursor_col_next = cursor_col + 1'b1;
            end
            tcs_pkg::CH_E: op.kind = tcs_pkg::OP_ERASE;
            tcs_pkg::CH_H: begin
              cursor_row_next = '0;
              cursor_col_next = '0;
            end
            tcs_pkg::CH_I: insert_flag_next = 1'b1;
            tcs_pkg::CH_O: insert_flag_next = 1'b0;
            tcs_pkg::CH_CARET: do_put = 1'b1;
            default: begin
              if (is_digit) begin
                pending_row_next = (digit >= NUM_ROWS) ? LAST_ROW : digit;
                phase_next       = tcs_pkg::PH_ROW;
              end
            end
          endcase
        end
        tcs_pkg::PH_ROW: begin
          phase_next = tcs_pkg::PH_TEXT;
          if (is_digit) begin
            cursor_row_next = pending_row;
            cursor_col_next = (digit >= NUM_COLS) ? LAST_COL : digit;
          end
        end
        default: begin
          phase_next = tcs_pkg::PH_TEXT;
          if (byte_in == tcs_pkg::CH_CARET) begin
            phase_next = tcs_pkg::PH_CARET;
          end else begin
            do_put = 1'b1;
          end
        end
      endcase
      if (do_put) begin
        op.kind = tcs_pkg::OP_PUT;
        if (cursor_col < LAST_COL) cursor_col_next = cursor_col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= tcs_pkg::PH_TEXT;
      pending_row <= '0;
      cursor_row  <= '0;
      cursor_col  <= '0;
      insert_flag <= 1'b0;
    end else if (fire) begin
      phase       <= phase_next;
      pending_row <= pending_row_next;
      cursor_row  <= cursor_row_next;
      cursor_col  <= cursor_col_next;
      insert_flag <= insert_flag_next;
    end
  end

endmodule

### rtl/core/tcs_row_edit.sv
module tcs_row_edit #(
  parameter int SCREEN_COLS = tcs_pkg::SCREEN_COLS
) (
  input  tcs_pkg::row_op_t                             op,
  input  logic [SCREEN_COLS-1:0][tcs_pkg::CHAR_W-1:0]  old_row,
  output logic [SCREEN_COLS-1:0][tcs_pkg::CHAR_W-1:0]  new_row,
  output logic                                         we,
  output logic [tcs_pkg::CHAR_W-1:0]                   read_char
);

  localparam int CW = $clog2(SCREEN_COLS);

  logic [SCREEN_COLS-1:0][tcs_pkg::CHAR_W-1:0] shifted;

  // shifted[j] = old_row[j-1]
  assign shifted = {old_row[SCREEN_COLS-2:0], tcs_pkg::CH_SPACE};

  always_comb begin
    new_row   = old_row;
    we        = 1'b0;
    read_char = '0;
    unique case (op.kind)
      tcs_pkg::OP_PUT: begin
        we = 1'b1;
        for (int j = 0; j < SCREEN_COLS; j++) begin
          if (op.ins && (tcs_pkg::POS_W'(j) > op.col)) new_row[j] = shifted[j];
          if (tcs_pkg::POS_W'(j) == op.col) new_row[j] = op.ch;
        end
      end
      tcs_pkg::OP_ERASE: begin
        we = 1'b1;
        for (int j = 0; j < SCREEN_COLS; j++) begin
          if (tcs_pkg::POS_W'(j) >= op.col) new_row[j] = tcs_pkg::CH_SPACE;
        end
      end
      tcs_pkg::OP_READ: read_char = old_row[op.col[CW-1:0]];
      default: begin
      end
    endcase
  end

endmodule
